// ----- design/assert_macros.svh -----
// Assertion helpers used by the locator design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/u8cl_pkg.sv -----
package u8cl_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam logic [15:0] SHOWN_MAX   = 16'hFFFF;
    localparam logic [1:0]  CONT_PREFIX = 2'b10;

    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_VALUE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_VALUE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_VALUE = 8'hF0;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] wanted_index;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_of_run;
        logic        found;
        logic [15:0] char_total;
    } t_out;

    // Length of the character that a byte would open; 1 for anything that is not a lead.
    function automatic logic [2:0] lead_width(input logic [7:0] b);
        logic [2:0] w;
        w = 3'd1;
        if ((b & LEAD2_MASK) == LEAD2_VALUE) begin
            w = 3'd2;
        end else if ((b & LEAD3_MASK) == LEAD3_VALUE) begin
            w = 3'd3;
        end else if ((b & LEAD4_MASK) == LEAD4_VALUE) begin
            w = 3'd4;
        end
        return w;
    endfunction

endpackage

// ----- design/utf8_character_locator_top.sv -----
// Latency: the first result of a byte is shown in the cycle after the edge that accepts it.
// Throughput: one byte per cycle while the output is not stalled; a found character of N
// bytes keeps the input stalled while its run drains from the result buffer. That buffer
// drains one item a cycle unless stalled, and is refilled in the cycle its last item leaves.
// Reset (synchronous, active low) empties the result buffer and starts a fresh string.
`include "assert_macros.svh"

module utf8_character_locator_top #(
    parameter int COUNT_WIDTH = u8cl_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  u8cl_pkg::t_in   i_in,
    output logic            o_valid,
    input  logic            i_stall,
    output u8cl_pkg::t_out  o_out
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] cnt;
        logic                   hit;
    } t_take;

    // One character counted: saturating increment and compare with the wanted position.
    function automatic t_take take_char(input logic [COUNT_WIDTH-1:0] cnt, input logic done,
                                        input logic [15:0] target);
        t_take t;
        t.cnt = cnt;
        t.hit = 1'b0;
        if (!done && cnt != CountMax) begin
            t.cnt = cnt + COUNT_WIDTH'(1);
            t.hit = (CMP_W'(t.cnt) == CMP_W'(target));
        end
        return t;
    endfunction

    function automatic logic [15:0] shown(input logic [COUNT_WIDTH-1:0] cnt);
        logic [CMP_W-1:0] w;
        w = CMP_W'(cnt);
        if (w > CMP_W'(u8cl_pkg::SHOWN_MAX)) begin
            return u8cl_pkg::SHOWN_MAX;
        end
        return w[15:0];
    endfunction

    // String state
    logic [7:0]             r_la [0:2];
    logic [7:0]             n_la [0:2];
    logic [1:0]             r_fill, n_fill;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [15:0]            r_target, n_target;
    logic                   r_done, n_done;
    logic                   r_started, n_started;

    // Result buffer
    logic [7:0]  r_res_bytes [0:3];
    logic [2:0]  r_res_left;
    logic [1:0]  r_res_idx;
    logic        r_res_found;
    logic [15:0] r_res_count;

    // Results of the byte being accepted
    logic [7:0]  res_bytes [0:3];
    logic [2:0]  res_len;
    logic        res_valid;
    logic        res_found;
    logic [15:0] res_count;

    logic        w_accept;
    logic        w_take_out;
    logic        w_load;
    logic [7:0]  data;
    logic [2:0]  need;
    logic        fresh;
    logic        end_str;
    t_take       tk;

    assign data       = i_in.data_byte;
    assign o_valid    = (r_res_left != 3'd0);
    assign o_stall    = (r_res_left > 3'd1) || ((r_res_left == 3'd1) && i_stall);
    assign w_accept   = i_valid && !o_stall;
    assign w_take_out = o_valid && !i_stall;
    assign w_load     = w_accept && res_valid;

    assign o_out.out_byte    = r_res_bytes[r_res_idx];
    assign o_out.last_of_run = (r_res_left == 3'd1);
    assign o_out.found       = r_res_found;
    assign o_out.char_total  = r_res_count;

    always_comb begin
        n_target  = r_started ? r_target : i_in.wanted_index;
        n_started = r_started;
        n_cnt     = r_cnt;
        n_done    = r_done;
        n_fill    = r_fill;
        for (int k = 0; k < 3; k++) begin
            n_la[k] = r_la[k];
        end
        for (int k = 0; k < 4; k++) begin
            res_bytes[k] = 8'd0;
        end
        res_len   = 3'd0;
        res_valid = 1'b0;
        res_found = 1'b0;
        res_count = 16'd0;
        need      = u8cl_pkg::lead_width(r_la[0]);
        fresh     = 1'b0;
        end_str   = 1'b0;
        tk        = '0;

        if (w_accept) begin
            n_started = 1'b1;
            if (r_done) begin
                end_str = (data == 8'd0);
            end else begin
                fresh = 1'b1;
                if (r_fill != 2'd0) begin
                    if (data[7:6] == u8cl_pkg::CONT_PREFIX) begin
                        fresh = 1'b0;
                        if (({1'b0, r_fill} + 3'd1) >= need) begin
                            tk     = take_char(r_cnt, r_done, n_target);
                            n_cnt  = tk.cnt;
                            n_fill = 2'd0;
                            if (tk.hit) begin
                                n_done    = 1'b1;
                                res_valid = 1'b1;
                                res_found = 1'b1;
                                res_len   = {1'b0, r_fill} + 3'd1;
                                for (int k = 0; k < 3; k++) begin
                                    res_bytes[k] = r_la[k];
                                end
                                res_bytes[r_fill] = data;
                                res_count = shown(tk.cnt);
                            end
                        end else begin
                            n_la[r_fill] = data;
                            n_fill       = r_fill + 2'd1;
                        end
                    end else begin
                        // Broken sequence: every held byte counts as a character of its own.
                        for (int k = 0; k < 3; k++) begin
                            if (2'(k) < r_fill) begin
                                tk    = take_char(n_cnt, n_done, n_target);
                                n_cnt = tk.cnt;
                                if (tk.hit) begin
                                    n_done       = 1'b1;
                                    res_valid    = 1'b1;
                                    res_found    = 1'b1;
                                    res_len      = 3'd1;
                                    res_bytes[0] = r_la[k];
                                    res_count    = shown(tk.cnt);
                                end
                            end
                        end
                        n_fill = 2'd0;
                        if (n_done) begin
                            fresh   = 1'b0;
                            end_str = (data == 8'd0);
                        end
                    end
                end

                if (fresh) begin
                    if (data == 8'd0) begin
                        res_valid = 1'b1;
                        res_found = 1'b0;
                        res_len   = 3'd1;
                        res_count = shown(n_cnt);
                        end_str   = 1'b1;
                    end else if (u8cl_pkg::lead_width(data) == 3'd1) begin
                        tk    = take_char(n_cnt, n_done, n_target);
                        n_cnt = tk.cnt;
                        if (tk.hit) begin
                            n_done       = 1'b1;
                            res_valid    = 1'b1;
                            res_found    = 1'b1;
                            res_len      = 3'd1;
                            res_bytes[0] = data;
                            res_count    = shown(tk.cnt);
                        end
                    end else begin
                        n_la[0] = data;
                        n_fill  = 2'd1;
                    end
                end
            end

            if (end_str) begin
                n_fill    = 2'd0;
                n_cnt     = '0;
                n_done    = 1'b0;
                n_started = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_la[k] <= n_la[k];
        end
        if (!i_rst_n) begin
            r_fill    <= 2'd0;
            r_cnt     <= '0;
            r_target  <= 16'd0;
            r_done    <= 1'b0;
            r_started <= 1'b0;
        end else begin
            r_fill    <= n_fill;
            r_cnt     <= n_cnt;
            r_target  <= n_target;
            r_done    <= n_done;
            r_started <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && res_valid) begin
            for (int k = 0; k < 4; k++) begin
                r_res_bytes[k] <= res_bytes[k];
            end
            r_res_found <= res_found;
            r_res_count <= res_count;
        end
        if (!i_rst_n) begin
            r_res_left <= 3'd0;
            r_res_idx  <= 2'd0;
        end else if (w_accept && res_valid) begin
            r_res_left <= res_len;
            r_res_idx  <= 2'd0;
        end else if (w_take_out) begin
            r_res_left <= r_res_left - 3'd1;
            r_res_idx  <= r_res_idx + 2'd1;
        end
    end

    `ASSERT_IMPL(a_done_no_fill, r_done, r_fill == 2'd0, "lookahead held after the match")
    `ASSERT_NEXT(a_found_shown, w_load && res_found, o_valid && o_out.found, "found run not shown")
    `ASSERT_NEXT(a_notfound_restart, w_load && !res_found, !r_started && r_cnt == '0, "no restart")
    `ASSERT_NEXT(a_drain_empty, w_take_out && o_out.last_of_run && !w_load, !o_valid, "not empty")

endmodule

// ----- tb/tb_utf8_character_locator_top.sv -----
module tb_utf8_character_locator_top;

    localparam longint unsigned COUNT_LIMIT =
        (64'd1 << u8cl_pkg::COUNT_WIDTH_DEFAULT) - 64'd1;
    localparam int unsigned LONG_HOLD = 100;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef logic [7:0] t_text_q [$];

    class locator_scoreboard;
        u8cl_pkg::t_out expected_q[$];
        logic [3:0][7:0] held_bytes;
        int unsigned held_count;
        longint unsigned char_counter;
        logic [15:0] target_pos;
        bit matched;
        bit in_string;
        int unsigned failures;

        function new();
            held_bytes = '0;
            target_pos = '0;
            failures = 0;
            end_string();
        endfunction

        function void end_string();
            held_count = 0;
            char_counter = 0;
            matched = 1'b0;
            in_string = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function int unsigned char_len(logic [7:0] b);
            if ((b & u8cl_pkg::LEAD2_MASK) == u8cl_pkg::LEAD2_VALUE) return 2;
            if ((b & u8cl_pkg::LEAD3_MASK) == u8cl_pkg::LEAD3_VALUE) return 3;
            if ((b & u8cl_pkg::LEAD4_MASK) == u8cl_pkg::LEAD4_VALUE) return 4;
            return 1;
        endfunction

        function void push_item(logic [7:0] b, bit last, bit hit);
            u8cl_pkg::t_out r;
            r.out_byte = b;
            r.last_of_run = last;
            r.found = hit;
            r.char_total = (char_counter > u8cl_pkg::SHOWN_MAX) ? u8cl_pkg::SHOWN_MAX
                                                                 : 16'(char_counter);
            expected_q.push_back(r);
        endfunction

        // One complete character; the wanted one is expected as a run of its bytes.
        function void count_char(logic [3:0][7:0] chars, int unsigned len);
            int unsigned i;
            if (matched || char_counter >= COUNT_LIMIT) return;
            char_counter++;
            if (char_counter == target_pos) begin
                for (i = 0; i < len; i++) begin
                    push_item(chars[i], (i + 1) == len, 1'b1);
                end
                matched = 1'b1;
            end
        endfunction

        function void note_byte(u8cl_pkg::t_in t);
            logic [7:0] b;
            int unsigned need;
            int unsigned i;
            b = t.data_byte;
            if (!in_string) begin
                target_pos = t.wanted_index;
                in_string = 1'b1;
            end
            if (matched) begin
                if (b == 8'h00) end_string();
                return;
            end
            if (held_count > 0) begin
                need = char_len(held_bytes[0]);
                if (b[7:6] == u8cl_pkg::CONT_PREFIX && held_count < 4) begin
                    held_bytes[held_count] = b;
                    held_count++;
                    if (held_count >= need) begin
                        count_char(held_bytes, held_count);
                        held_count = 0;
                    end
                    return;
                end
                // The sequence broke: every held byte stands as a character of its own.
                for (i = 0; i < held_count; i++) begin
                    count_char(32'(held_bytes[i]), 1);
                end
                held_count = 0;
                if (matched) begin
                    if (b == 8'h00) end_string();
                    return;
                end
            end
            if (b == 8'h00) begin
                push_item(8'h00, 1'b1, 1'b0);
                end_string();
                return;
            end
            if (char_len(b) == 1) begin
                count_char(32'(b), 1);
            end else begin
                held_bytes[0] = b;
                held_count = 1;
            end
        endfunction

        function void check_result(u8cl_pkg::t_out got);
            u8cl_pkg::t_out want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("unexpected result: byte %02h last %0d found %0d count %0d",
                             got.out_byte, got.last_of_run, got.found, got.char_total);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run ||
                got.found !== want.found || got.char_total !== want.char_total) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("mismatch: expected byte %02h last %0d found %0d count %0d",
                             want.out_byte, want.last_of_run, want.found, want.char_total);
                    $display("          actual   byte %02h last %0d found %0d count %0d",
                             got.out_byte, got.last_of_run, got.found, got.char_total);
                end
            end
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_stall;
    u8cl_pkg::t_in  i_in = '0;
    logic           o_valid;
    logic           i_stall = 1'b0;
    u8cl_pkg::t_out o_out;

    locator_scoreboard sb = new();
    int unsigned quiet_cycles = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    bit no_gaps = 1'b0;
    bit hold_request = 1'b0;

    utf8_character_locator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_byte(i_in);
            if (o_valid && !i_stall) sb.check_result(o_out);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    initial begin : watchdog
        @(negedge i_clk);
        while (quiet_cycles < QUIET_LIMIT) @(negedge i_clk);
        $display("FAIL utf8_character_locator_top");
        $finish;
    end

    // The result side stalls in stretches of random density, and holds off for a long
    // stretch when asked so that the block backs up into its input.
    initial begin : receiver
        int unsigned span;
        int unsigned busy_pct;
        @(posedge i_clk);
        forever begin
            span = $urandom_range(4, 40);
            case ($urandom_range(0, 3))
                0: begin
                    busy_pct = 0;
                end
                1: begin
                    busy_pct = 25;
                end
                2: begin
                    busy_pct = 50;
                end
                default: begin
                    busy_pct = 85;
                end
            endcase
            while (span > 0 && !hold_request) begin
                i_stall <= ($urandom_range(0, 99) < busy_pct);
                @(posedge i_clk);
                span--;
            end
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [15:0] w);
        u8cl_pkg::t_in it;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        it.data_byte = b;
        it.wanted_index = w;
        i_in <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Only the first byte's index matters; the rest carry noise there.
    task automatic send_string(input t_text_q text, input logic [15:0] wanted);
        int unsigned k;
        for (k = 0; k < text.size(); k++) begin
            send_byte(text[k], (k == 0) ? wanted : 16'($urandom));
        end
        send_byte(8'h00, (text.size() == 0) ? wanted : 16'($urandom));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [7:0] lead_of(int unsigned w);
        case (w)
            2: return {3'b110, 5'($urandom)};
            3: return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    // Mostly well-formed characters, with cut-short sequences and stray bytes mixed in.
    function automatic t_text_q random_text(int unsigned units);
        t_text_q t;
        int unsigned u;
        int unsigned w;
        int unsigned k;
        int unsigned n_cont;
        for (u = 0; u < units; u++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    t.push_back(8'($urandom_range(1, 127)));
                end
                3, 4, 5, 6: begin
                    w = $urandom_range(2, 4);
                    t.push_back(lead_of(w));
                    for (k = 1; k < w; k++) t.push_back(cont_byte());
                end
                7: begin
                    w = $urandom_range(2, 4);
                    t.push_back(lead_of(w));
                    n_cont = $urandom_range(0, w - 2);
                    for (k = 0; k < n_cont; k++) t.push_back(cont_byte());
                end
                8: begin
                    t.push_back(cont_byte());
                end
                default: begin
                    t.push_back(8'($urandom_range(8'hF8, 8'hFF)));
                end
            endcase
        end
        return t;
    endfunction

    function automatic logic [15:0] pick_wanted(int unsigned n_bytes);
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'($urandom);
            2: return 16'(n_bytes + $urandom_range(1, 3));
            default: return 16'($urandom_range(1, (n_bytes > 0) ? n_bytes : 1));
        endcase
    endfunction

    initial begin : stimulus
        t_text_q text;
        int unsigned random_end;
        int unsigned pressure_at;
        bit pressure_done;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        text.delete();
        send_string(text, 16'd1);
        text = '{8'h41};
        send_string(text, 16'd1);
        // Position zero never matches.
        text = '{8'h41, 8'h42};
        send_string(text, 16'd0);
        text = '{8'hF0, 8'h9F, 8'h98, 8'h80};
        send_string(text, 16'd1);
        // A lead followed by a plain byte counts as a character by itself.
        text = '{8'hC3, 8'h41};
        send_string(text, 16'd2);
        text = '{8'hE2, 8'h82};
        send_string(text, 16'd5);
        // The wanted character is found among the bytes of a broken sequence.
        text = '{8'hF0, 8'h80, 8'h41};
        send_string(text, 16'd2);
        text = '{8'hFF, 8'hBF};
        send_string(text, 16'hFFFF);
        wait_drained();

        random_end = items_sent + 170;
        pressure_at = items_sent + $urandom_range(40, 120);
        pressure_done = 1'b0;
        while (items_sent < random_end) begin
            if (!pressure_done && items_sent >= pressure_at) begin
                wait_drained();
                hold_request = 1'b1;
                no_gaps = 1'b1;
                repeat (12) send_string(random_text($urandom_range(1, 3)), 16'd1);
                no_gaps = 1'b0;
                pressure_done = 1'b1;
            end
            text = random_text(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                            : $urandom_range(1, 10));
            send_string(text, pick_wanted(text.size()));
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("PASS utf8_character_locator_top");
        end else begin
            $display("FAIL utf8_character_locator_top");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/u8cl_pkg.sv
design/utf8_character_locator_top.sv
tb/tb_utf8_character_locator_top.sv
